// ----- design/mtar_pkg.sv -----
// Shared types, codes and helpers of the all-reduce sum unit.
// No dependencies; mtar_fifo, mtar_front, mtar_back and the top level refer to this package.
package mtar_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int MAX_RANKS_DEF    = 8;
  localparam int Q_DEPTH          = 4;

  // number_type codes
  localparam logic [2:0] NT_F32  = 3'd0;
  localparam logic [2:0] NT_F64  = 3'd1;
  localparam logic [2:0] NT_I32  = 3'd2;
  localparam logic [2:0] NT_I64  = 3'd3;
  localparam logic [2:0] NT_BF16 = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_NUMBER_TYPE   = 2'd0;
  localparam logic [1:0] CFG_RANKS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic        first;
    logic        last_rank;
    logic        last_elem;
    logic [2:0]  ntype;
    logic [9:0]  idx;
    logic [63:0] operand;
  } item_t;

  // round float32 bits to bfloat16, nearest-even, no NaN special case
  function automatic logic [15:0] round_bf16(input logic [31:0] b);
    logic [31:0] t;
    t = b + 32'h0000_7fff + {31'b0, b[16]};
    return t[31:16];
  endfunction

endpackage

// ----- design/mtar_ifs.sv -----
// Channel interfaces of the all-reduce sum unit: input items, results, config writes.
// Depends on nothing; used by mtar_front, mtar_back and the top level.
interface mtar_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rank;
  logic [9:0]  element_index;
  logic [63:0] operand_bits;
  modport source (output valid, rank, element_index, operand_bits, input ready);
  modport sink   (input valid, rank, element_index, operand_bits, output ready);
endinterface

interface mtar_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sum_bits;
  logic [9:0]  result_index;
  logic        last_element;
  modport source (output valid, sum_bits, result_index, last_element, input ready);
  modport sink   (input valid, sum_bits, result_index, last_element, output ready);
endinterface

interface mtar_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/mtar_fifo.sv -----
// Short item queue between the front and back parts.
// Depends on mtar_pkg (item_t).
module mtar_fifo #(
  parameter int DEPTH = mtar_pkg::Q_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mtar_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output mtar_pkg::item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtar_pkg::item_t  store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/mtar_fpadd.sv -----
// Pipelined IEEE binary floating-point adder, round to nearest-even, with subnormals.
// Three register stages; result is combinational off the last. No package use.
module mtar_fpadd #(
  parameter int EW = 8,
  parameter int FW = 23
) (
  input  logic              clk,
  input  logic              en,
  input  logic [EW+FW:0]    a,
  input  logic [EW+FW:0]    b,
  output logic [EW+FW:0]    y
);

  localparam int W  = EW + FW + 1;
  localparam int M  = FW + 1;      // mantissa with hidden bit
  localparam int X  = M + 3;       // plus guard, round, sticky
  localparam int S  = X + 1;       // plus carry
  localparam int LW = $clog2(X + 1);
  localparam logic [EW-1:0] EMAX = '1;

  // ---- stage A: unpack, order by magnitude, specials
  logic          sa, sb, a_nan, b_nan, a_inf, b_inf, swap;
  logic [EW-1:0] ea, eb, e_big, e_sml;
  logic [FW-1:0] fa, fb;
  logic [W-1:0]  a_q, b_q, spec_val;

  always_comb begin
    sa    = a[W-1];
    sb    = b[W-1];
    ea    = a[W-2:FW];
    eb    = b[W-2:FW];
    fa    = a[FW-1:0];
    fb    = b[FW-1:0];
    a_nan = (ea == EMAX) && (fa != '0);
    b_nan = (eb == EMAX) && (fb != '0);
    a_inf = (ea == EMAX) && (fa == '0);
    b_inf = (eb == EMAX) && (fb == '0);
    swap  = b[W-2:0] > a[W-2:0];
    e_big = swap ? eb : ea;
    e_sml = swap ? ea : eb;
    if (e_big == '0) e_big = EW'(1);
    if (e_sml == '0) e_sml = EW'(1);
    a_q = a;
    a_q[FW-1] = 1'b1;
    b_q = b;
    b_q[FW-1] = 1'b1;
    priority if (a_nan) begin
      spec_val = a_q;
    end else if (b_nan) begin
      spec_val = b_q;
    end else if (a_inf && b_inf && (sa != sb)) begin
      spec_val = {1'b1, EMAX, 1'b1, {(FW-1){1'b0}}};
    end else if (a_inf) begin
      spec_val = a;
    end else begin
      spec_val = b;
    end
  end

  logic          r1_sign_r, r1_sub_r, r1_spec_r, r1_zsign_r;
  logic [EW-1:0] r1_e_r, r1_d_r;
  logic [M-1:0]  r1_mb_r, r1_ms_r;
  logic [W-1:0]  r1_sval_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sign_r  <= swap ? sb : sa;
      r1_sub_r   <= sa ^ sb;
      r1_spec_r  <= (ea == EMAX) || (eb == EMAX);
      r1_zsign_r <= sa & sb;
      r1_e_r     <= e_big;
      r1_d_r     <= e_big - e_sml;
      r1_mb_r    <= swap ? {eb != '0, fb} : {ea != '0, fa};
      r1_ms_r    <= swap ? {ea != '0, fa} : {eb != '0, fb};
      r1_sval_r  <= spec_val;
    end
  end

  // ---- stage B: align smaller operand with sticky, add or subtract
  logic [X-1:0] sml_x, sh;
  logic         st;
  logic [S-1:0] big_x, al, sum;

  always_comb begin
    sml_x = {r1_ms_r, 3'b000};
    big_x = {1'b0, r1_mb_r, 3'b000};
    if (32'(r1_d_r) >= 32'(X)) begin
      sh = '0;
      st = |r1_ms_r;
    end else begin
      sh = sml_x >> r1_d_r;
      st = (sh << r1_d_r) != sml_x;
    end
    al  = {1'b0, sh[X-1:1], sh[0] | st};
    sum = r1_sub_r ? big_x - al : big_x + al;
  end

  logic          r2_sign_r, r2_spec_r, r2_zsign_r;
  logic [EW:0]   r2_e_r;
  logic [S-1:0]  r2_sum_r;
  logic [W-1:0]  r2_sval_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_sign_r  <= r1_sign_r;
      r2_spec_r  <= r1_spec_r;
      r2_zsign_r <= r1_zsign_r;
      r2_e_r     <= {1'b0, r1_e_r};
      r2_sum_r   <= sum;
      r2_sval_r  <= r1_sval_r;
    end
  end

  // ---- stage C: normalize (leading-zero count, limited by exponent)
  logic [LW-1:0] lz;
  logic [EW:0]   lim, shamt, e_n;
  logic [X-1:0]  n;

  always_comb begin
    lz = LW'(X);
    for (int i = 0; i < X; i++) begin
      if (r2_sum_r[i]) lz = LW'(X - 1 - i);
    end
    lim   = r2_e_r - 1'b1;
    shamt = ((EW+1)'(lz) < lim) ? (EW+1)'(lz) : lim;
    if (r2_sum_r[S-1]) begin
      n   = {r2_sum_r[S-1:2], r2_sum_r[1] | r2_sum_r[0]};
      e_n = r2_e_r + 1'b1;
    end else begin
      n   = r2_sum_r[X-1:0] << shamt;
      e_n = r2_e_r - shamt;
    end
  end

  logic          r3_sign_r, r3_spec_r, r3_zsign_r, r3_zero_r;
  logic [EW:0]   r3_e_r;
  logic [X-1:0]  r3_n_r;
  logic [W-1:0]  r3_sval_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_sign_r  <= r2_sign_r;
      r3_spec_r  <= r2_spec_r;
      r3_zsign_r <= r2_zsign_r;
      r3_zero_r  <= (r2_sum_r == '0);
      r3_e_r     <= e_n;
      r3_n_r     <= n;
      r3_sval_r  <= r2_sval_r;
    end
  end

  // ---- stage D: round to nearest-even and pack
  logic          up;
  logic [M:0]    mr;
  logic [EW:0]   e_f;
  logic [FW-1:0] frac;

  always_comb begin
    up = r3_n_r[2] & (r3_n_r[1] | r3_n_r[0] | r3_n_r[3]);
    mr = {1'b0, r3_n_r[X-1:3]} + (M+1)'(up);
    if (mr[M]) begin
      e_f  = r3_e_r + 1'b1;
      frac = '0;
    end else begin
      e_f  = mr[M-1] ? r3_e_r : '0;
      frac = mr[M-2:0];
    end
    if (r3_spec_r) begin
      y = r3_sval_r;
    end else if (r3_zero_r) begin
      y = {r3_zsign_r, {(W-1){1'b0}}};
    end else if (e_f >= {1'b0, EMAX}) begin
      y = {r3_sign_r, EMAX, {FW{1'b0}}};
    end else begin
      y = {r3_sign_r, e_f[EW-1:0], frac};
    end
  end

endmodule

// ----- design/mtar_front.sv -----
// Front part: configuration registers, input acceptance and item classification.
// Depends on mtar_pkg and the channel interfaces in mtar_ifs.
module mtar_front #(
  parameter int MAX_ELEMENTS = mtar_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_RANKS    = mtar_pkg::MAX_RANKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mtar_in_if.sink          in_ch,
  mtar_cfg_if.sink         cfg_ch,
  input  logic             q_full,
  output logic             push,
  output mtar_pkg::item_t  push_item
);

  logic [2:0]  number_type_r;
  logic [3:0]  ranks_r;
  logic [10:0] elems_r;
  logic [6:0]  nr;
  logic [16:0] ne;
  logic        keep;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_type_r <= mtar_pkg::NT_F32;
      ranks_r       <= 4'd1;
      elems_r       <= 11'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mtar_pkg::CFG_NUMBER_TYPE:   number_type_r <= cfg_ch.data[2:0];
        mtar_pkg::CFG_RANKS_IN_USE:  ranks_r       <= cfg_ch.data[3:0];
        mtar_pkg::CFG_ELEMENT_COUNT: elems_r       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamp to 1..MAX
  always_comb begin
    if (ranks_r == '0) nr = 7'd1;
    else if (7'(ranks_r) > 7'(MAX_RANKS)) nr = 7'(MAX_RANKS);
    else nr = 7'(ranks_r);
    if (elems_r == '0) ne = 17'd1;
    else if (17'(elems_r) > 17'(MAX_ELEMENTS)) ne = 17'(MAX_ELEMENTS);
    else ne = 17'(elems_r);
  end

  assign keep = (number_type_r <= mtar_pkg::NT_BF16) && (7'(in_ch.rank) < nr) &&
                (17'(in_ch.element_index) < ne);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && keep;

  always_comb begin
    push_item.first     = (in_ch.rank == '0);
    push_item.last_rank = (7'(in_ch.rank) + 7'd1 == nr);
    push_item.last_elem = (17'(in_ch.element_index) + 17'd1 == ne);
    push_item.ntype     = number_type_r;
    push_item.idx       = in_ch.element_index;
    push_item.operand   = in_ch.operand_bits;
  end

endmodule

// ----- design/mtar_back.sv -----
// Back part: accumulator memory, read-add-write pipeline and result register.
// Depends on mtar_pkg, mtar_fpadd and the result interface in mtar_ifs.
module mtar_back #(
  parameter int MAX_ELEMENTS = mtar_pkg::MAX_ELEMENTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  mtar_pkg::item_t q_head,
  output logic            q_pop,
  mtar_out_if.source      out_ch
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  typedef struct packed {
    logic       last_rank;
    logic       last_elem;
    logic [2:0] ntype;
    logic [9:0] idx;
  } meta_t;

  logic [63:0] mem [MAX_ELEMENTS];

  logic        en, hazard, issue;
  logic        s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  meta_t       s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r, s5_meta_r, q_meta;
  logic        s1_first_r;
  logic [63:0] s1_opnd_r, rd_data_r;
  logic [63:0] s2_isum_r, s3_isum_r, s4_isum_r, s5_sum_r;
  logic        out_valid_r;
  logic [63:0] out_sum_r;
  logic [9:0]  out_idx_r;
  logic        out_last_r;

  logic [63:0] acc, isum, fsum;
  logic [31:0] b32, f32_y;
  logic [63:0] f64_y;
  logic [63:0] out_bits;

  assign en = !out_valid_r || out_ch.ready;

  always_comb begin
    q_meta.last_rank = q_head.last_rank;
    q_meta.last_elem = q_head.last_elem;
    q_meta.ntype     = q_head.ntype;
    q_meta.idx       = q_head.idx;
  end

  // an item waits while an earlier write to its entry is still in flight
  assign hazard =
    (s1_valid_r && !s1_meta_r.last_rank && s1_meta_r.idx == q_head.idx) ||
    (s2_valid_r && !s2_meta_r.last_rank && s2_meta_r.idx == q_head.idx) ||
    (s3_valid_r && !s3_meta_r.last_rank && s3_meta_r.idx == q_head.idx) ||
    (s4_valid_r && !s4_meta_r.last_rank && s4_meta_r.idx == q_head.idx) ||
    (s5_valid_r && !s5_meta_r.last_rank && s5_meta_r.idx == q_head.idx);

  assign issue = q_nonempty && !hazard && en;
  assign q_pop = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r && s5_meta_r.last_rank;
    end
  end

  // memory: registered read at issue, write at retire
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[AW'(q_head.idx)];
    end
    if (en && s5_valid_r && !s5_meta_r.last_rank) begin
      mem[AW'(s5_meta_r.idx)] <= s5_sum_r;
    end
  end

  // stage 1: pick accumulator, integer sums, feed float adders
  always_comb begin
    acc  = s1_first_r ? 64'd0 : rd_data_r;
    b32  = (s1_meta_r.ntype == mtar_pkg::NT_BF16) ? {s1_opnd_r[15:0], 16'h0000}
                                                  : s1_opnd_r[31:0];
    isum = (s1_meta_r.ntype == mtar_pkg::NT_I32) ? {32'd0, acc[31:0] + s1_opnd_r[31:0]}
                                                 : acc + s1_opnd_r;
  end

  mtar_fpadd #(.EW(8), .FW(23)) u_add32 (
    .clk (clk),
    .en  (en),
    .a   (acc[31:0]),
    .b   (b32),
    .y   (f32_y)
  );

  mtar_fpadd #(.EW(11), .FW(52)) u_add64 (
    .clk (clk),
    .en  (en),
    .a   (acc),
    .b   (s1_opnd_r),
    .y   (f64_y)
  );

  always_comb begin
    unique case (s4_meta_r.ntype)
      mtar_pkg::NT_F32, mtar_pkg::NT_BF16: fsum = {32'd0, f32_y};
      mtar_pkg::NT_F64:                    fsum = f64_y;
      default:                             fsum = s4_isum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (issue) begin
        s1_meta_r  <= q_meta;
        s1_first_r <= q_head.first;
        s1_opnd_r  <= q_head.operand;
      end
      s2_meta_r <= s1_meta_r;
      s2_isum_r <= isum;
      s3_meta_r <= s2_meta_r;
      s3_isum_r <= s2_isum_r;
      s4_meta_r <= s3_meta_r;
      s4_isum_r <= s3_isum_r;
      s5_meta_r <= s4_meta_r;
      s5_sum_r  <= fsum;
    end
  end

  assign out_bits = (s5_meta_r.ntype == mtar_pkg::NT_BF16)
                    ? {48'd0, mtar_pkg::round_bf16(s5_sum_r[31:0])} : s5_sum_r;

  always_ff @(posedge clk) begin
    if (en && s5_valid_r && s5_meta_r.last_rank) begin
      out_sum_r  <= out_bits;
      out_idx_r  <= s5_meta_r.idx;
      out_last_r <= s5_meta_r.last_elem;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sum_bits     = out_sum_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.last_element = out_last_r;

endmodule

// ----- design/multi_type_allreduce_sum_unit.sv -----
// Top level of the element-wise all-reduce sum unit.
// Depends on mtar_pkg, mtar_ifs, mtar_front, mtar_fifo and mtar_back.
//
// Usage:
//  cfg_ch  : register writes (0 number type, 1 ranks in use, 2 element count),
//            always ready; write only while no transaction is in flight.
//  in_ch   : one element per transaction (rank, element index, operand bits).
//            Items with unknown type, rank or index out of range are dropped.
//  out_ch  : one sum per element, emitted with the last rank's transaction.
//  Throughput: one input transaction per cycle while the queue has room. An
//  item whose accumulator entry is still being updated by an earlier rank
//  waits in the issue queue until that write retires.
//  Path: an accepted input is queued, then passes the memory read, three
//  float adder stages, retire and the output register.
//  Reset: control state clears; registers return to float32, 1 rank, 1
//  element. The accumulator memory is not cleared; rank 0 never uses its contents.
//  Receiver stall: the output register holds and the back pipeline freezes;
//  the front keeps accepting until the 4-entry queue is full.
module multi_type_allreduce_sum_unit #(
  parameter int MAX_ELEMENTS = mtar_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_RANKS    = mtar_pkg::MAX_RANKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mtar_in_if.sink     in_ch,
  mtar_out_if.source  out_ch,
  mtar_cfg_if.sink    cfg_ch
);

  logic            push, q_full, q_pop, q_nonempty;
  mtar_pkg::item_t push_item, q_head;

  mtar_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_RANKS    (MAX_RANKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  mtar_fifo #(
    .DEPTH (mtar_pkg::Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  mtar_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- test/tb_multi_type_allreduce_sum_unit.sv -----
// Testbench of multi_type_allreduce_sum_unit: directed and random reduction traffic.
// A software predictor of the summed elements is checked against every result.
// Depends on mtar_pkg, the mtar channel interfaces and the unit itself.
`timescale 1ns / 1ps

module tb_multi_type_allreduce_sum_unit;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 12;

  typedef struct {
    logic [63:0] sum_bits;
    logic [9:0]  index;
    logic        last;
  } elem_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mtar_in_if  in_ch();
  mtar_out_if out_ch();
  mtar_cfg_if cfg_ch();

  multi_type_allreduce_sum_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and the accumulator store
  logic [2:0]  num_type;
  logic [3:0]  rank_reg;
  logic [10:0] elem_reg;
  logic [63:0] partial_store [0:1023];
  elem_sum_t   sums_due [$];

  int  errors = 0;
  int  cycles = 0;
  int  elems_sent = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  // float32 bits widened exactly to float64 bits
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [7:0]  e;
    logic [23:0] m;
    int          ex;
    e = f[30:23];
    m = {1'b0, f[22:0]};
    if (e == 8'd0 && m == 24'd0) return {f[31], 63'd0};
    if (e == 8'hff) return {f[31], 11'h7ff, f[22:0], 29'd0};
    if (e == 8'd0) begin
      ex = 1;
      while (!m[23]) begin
        m = m << 1;
        ex--;
      end
    end else begin
      ex = e;
      m[23] = 1'b1;
    end
    return {f[31], 11'(ex + 896), m[22:0], 29'd0};
  endfunction

  // float64 bits rounded to float32 bits, nearest-even; NaN keeps its top payload, quieted
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic [63:0] sig, q, rem, half;
    int          ex, shift;
    if (d[62:52] == 11'h7ff) begin
      if (d[51:0] == 52'd0) return {d[63], 8'hff, 23'd0};
      return {d[63], 8'hff, 1'b1, d[50:29]};
    end
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    ex = int'(d[62:52]) - 1023;
    if (ex > 127) return {d[63], 8'hff, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    shift = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (shift > 60) return {d[63], 31'd0};
    q = sig >> shift;
    half = 64'd1 << (shift - 1);
    rem = sig & ((64'd1 << shift) - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (ex >= -126) q = q + (64'(ex + 126) << 23);
    return {d[63], q[30:0]};
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    real r;
    r = $bitstoreal(widen_f32(a)) + $bitstoreal(widen_f32(b));
    return narrow_f64($realtobits(r));
  endfunction

  function automatic void accumulate(input logic [2:0] rank, input logic [9:0] idx,
                                     input logic [63:0] op);
    int          nr, ne;
    logic [63:0] acc, sum;
    logic [31:0] rb;
    elem_sum_t   e;
    nr = (rank_reg == 0) ? 1 : (rank_reg > 8) ? 8 : int'(rank_reg);
    ne = (elem_reg == 0) ? 1 : (elem_reg > 1024) ? 1024 : int'(elem_reg);
    if (num_type > mtar_pkg::NT_BF16 || int'(rank) >= nr || int'(idx) >= ne) return;
    acc = (rank == 0) ? 64'd0 : partial_store[idx];
    case (num_type)
      mtar_pkg::NT_F32: sum = {32'd0, add_f32(acc[31:0], op[31:0])};
      mtar_pkg::NT_F64: sum = $realtobits($bitstoreal(acc) + $bitstoreal(op));
      mtar_pkg::NT_I32: sum = {32'd0, acc[31:0] + op[31:0]};
      mtar_pkg::NT_I64: sum = acc + op;
      default: sum = {32'd0, add_f32(acc[31:0], {op[15:0], 16'd0})};
    endcase
    if (int'(rank) + 1 < nr) begin
      partial_store[idx] = sum;
      return;
    end
    if (num_type == mtar_pkg::NT_BF16) begin
      rb = sum[31:0] + 32'h7fff + {31'd0, sum[16]};
      sum = {48'd0, rb[31:16]};
    end
    e.sum_bits = sum;
    e.index = idx;
    e.last = (int'(idx) + 1 == ne);
    sums_due.insert(sums_due.size(), e);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sums_due.size() == 0) begin
        $error("unexpected result index %0d", out_ch.result_index);
        errors++;
      end else begin
        elem_sum_t e;
        e = sums_due.pop_front();
        if (out_ch.sum_bits !== e.sum_bits) begin
          $error("sum_bits: expected %h actual %h", e.sum_bits, out_ch.sum_bits);
          errors++;
        end
        if (out_ch.result_index !== e.index) begin
          $error("result_index: expected %0d actual %0d", e.index, out_ch.result_index);
          errors++;
        end
        if (out_ch.last_element !== e.last) begin
          $error("last_element: expected %0b actual %0b", e.last, out_ch.last_element);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // all tasks enter and leave at a falling edge
  task automatic send_elem(input logic [2:0] rank, input logic [9:0] idx,
                           input logic [63:0] op);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.rank = rank;
    in_ch.element_index = idx;
    in_ch.operand_bits = op;
    do @(posedge clk); while (!in_ch.ready);
    accumulate(rank, idx, op);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      mtar_pkg::CFG_NUMBER_TYPE:  num_type = data[2:0];
      mtar_pkg::CFG_RANKS_IN_USE: rank_reg = data[3:0];
      default:                    elem_reg = data;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic setup(input logic [10:0] nt, input logic [10:0] nr, input logic [10:0] ne);
    drain();
    write_reg(mtar_pkg::CFG_NUMBER_TYPE, nt);
    write_reg(mtar_pkg::CFG_RANKS_IN_USE, nr);
    write_reg(mtar_pkg::CFG_ELEMENT_COUNT, ne);
  endtask

  task automatic test_reset_defaults();
    send_elem(3'd0, 10'd0, 64'h0000_0000_8000_0000);   // -0 + +0 gives +0
    send_elem(3'd0, 10'd0, 64'hdead_beef_3f80_0000);   // upper bits ignored
    send_elem(3'd1, 10'd0, 64'h3f80_0000);             // rank out of range
    send_elem(3'd0, 10'd1, 64'h3f80_0000);             // index out of range
  endtask

  task automatic test_float_edges();
    setup(mtar_pkg::NT_F32, 11'd2, 11'd2);
    send_elem(3'd0, 10'd0, 64'h7f7f_ffff);
    send_elem(3'd0, 10'd1, 64'h0000_0001);
    send_elem(3'd1, 10'd0, 64'h7f7f_ffff);             // overflow to inf
    send_elem(3'd1, 10'd1, 64'h8000_0001);             // denormals cancel
    setup(mtar_pkg::NT_F64, 11'd3, 11'd1);
    send_elem(3'd0, 10'd0, 64'h7fef_ffff_ffff_ffff);
    send_elem(3'd1, 10'd0, 64'h8000_0000_0000_0001);
    send_elem(3'd2, 10'd0, 64'hffef_ffff_ffff_ffff);
  endtask

  task automatic test_integer_wrap();
    setup(mtar_pkg::NT_I32, 11'd2, 11'd1);
    send_elem(3'd0, 10'd0, 64'hffff_ffff_7fff_ffff);
    send_elem(3'd1, 10'd0, 64'h0000_0000_0000_0001);
    setup(mtar_pkg::NT_I64, 11'd2, 11'd1);
    send_elem(3'd0, 10'd0, 64'hffff_ffff_ffff_ffff);
    send_elem(3'd1, 10'd0, 64'h0000_0000_0000_0001);
  endtask

  task automatic test_bf16_rounding();
    setup(mtar_pkg::NT_BF16, 11'd2, 11'd2);
    send_elem(3'd0, 10'd0, 64'hffff_ffff_ffff_3f80);
    send_elem(3'd0, 10'd1, 64'h7f7f);
    send_elem(3'd1, 10'd0, 64'h3381);                  // below one bf16 ulp
    send_elem(3'd1, 10'd1, 64'h7f7f);                  // overflow to inf
  endtask

  task automatic test_ignored_and_clamped();
    setup(11'd5, 11'd1, 11'd1);                         // unknown number type
    send_elem(3'd0, 10'd0, 64'h1);
    setup(11'h7ff, 11'd0, 11'd0);                       // zero counts clamp to one
    send_elem(3'd0, 10'd0, 64'h1);
    setup(mtar_pkg::NT_I32, 11'd0, 11'd0);
    send_elem(3'd0, 10'd0, 64'h5);
    setup(mtar_pkg::NT_I64, 11'd15, 11'd2047);          // clamp to the maximum
    for (int r = 0; r < 8; r++) send_elem(3'(r), 10'd1023, 64'h1 << (8 * r + 7));
  endtask

  function automatic logic [63:0] rand_operand(input logic [2:0] nt);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (nt)
      mtar_pkg::NT_F32: v[30:23] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 250))
                                                               : 8'($urandom_range(120, 134));
      mtar_pkg::NT_F64: v[62:52] = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2040))
                                                               : 11'($urandom_range(1016, 1030));
      mtar_pkg::NT_BF16: v[14:7] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 250))
                                                               : 8'($urandom_range(120, 134));
      default: if ($urandom_range(0, 7) == 0) v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {63{v[0]}}};
    endcase
    return v;
  endfunction

  task automatic test_random_reduction();
    int nr, ne, nt, rounds;
    int order [1024];
    while (elems_sent < 1800) begin
      if (elems_sent > 1550) quiet = 1'b1;
      nt = $urandom_range(0, 4);
      if ($urandom_range(0, 20) == 0) begin
        setup(11'($urandom_range(5, 7)), 11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)));
        repeat (3) send_elem(3'($urandom), 10'($urandom), {$urandom, $urandom});
        continue;
      end
      nr = $urandom_range(1, 8);
      rounds = $urandom_range(1, 3);
      // now and then a long vector early in the run keeps the item total near its target
      if (elems_sent < 700 && $urandom_range(0, 30) == 0) begin
        ne = ($urandom_range(0, 1) == 0) ? 1024 : $urandom_range(100, 1023);
        nr = 1;
        rounds = 1;
      end else begin
        ne = $urandom_range(1, 12);
      end
      setup(11'(nt) | (11'($urandom_range(0, 255)) << 3),
            (nr == 8 && $urandom_range(0, 1)) ? 11'($urandom_range(9, 15)) : 11'(nr),
            (ne == 1024 && $urandom_range(0, 1)) ? 11'($urandom_range(1025, 2047))
                                                 : 11'(ne));
      repeat (rounds) begin
        for (int i = 0; i < ne; i++) order[i] = i;
        for (int i = ne - 1; i > 0; i--) begin
          int j, t;
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (int r = 0; r < nr; r++) begin
          for (int i = 0; i < ne; i++) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
              if (nr < 8) send_elem(3'($urandom_range(nr, 7)), 10'($urandom), {$urandom, $urandom});
              else if (ne < 1024)
                send_elem(3'($urandom), 10'($urandom_range(ne, 1023)), {$urandom, $urandom});
            end
            send_elem(3'(r), 10'(order[i]), rand_operand(3'(nt)));
            elems_sent++;
          end
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rank = '0;
    in_ch.element_index = '0;
    in_ch.operand_bits = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mtar_pkg::CFG_NUMBER_TYPE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    num_type = mtar_pkg::NT_F32;
    rank_reg = 4'd1;
    elem_reg = 11'd1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_float_edges();
    test_integer_wrap();
    test_bf16_rounding();
    test_ignored_and_clamped();
    test_random_reduction();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
